### hw/rtl/unsigned_decimal_field_formatter_assert.svh
// Assertion macros shared by the checker of the decimal field formatter.
// Depends on nothing; included by files that carry concurrent assertions.
`ifndef UNSIGNED_DECIMAL_FIELD_FORMATTER_ASSERT_SVH
`define UNSIGNED_DECIMAL_FIELD_FORMATTER_ASSERT_SVH

// Property checked on every rising clock edge, masked while reset is low.
`define UDF_ASSERT(lbl, clk, rst_n, prop, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);

// Property checked on every rising clock edge, reset cycles included.
`define UDF_ASSERT_ALWAYS(lbl, clk, prop, msg) \
    lbl: assert property (@(posedge clk) prop) else $error(msg);

`endif

### hw/rtl/udf_pkg.sv
// Package for the unsigned decimal field formatter: sizes, character codes,
// register indexes, command/status structs and the width clamp function.
// Depends on nothing; imported by every RTL module of the block.
package udf_pkg;

    // Value and field limits
    localparam int VALUE_BITS  = 64;
    localparam int WIDTH_LIMIT = 62;

    // Decimal digits needed for VALUE_BITS bits: floor(bits * log10(2)) + 1
    localparam int DEC_DIGITS = (VALUE_BITS * 30103) / 100000 + 1;
    localparam int MAX_CHARS  = (WIDTH_LIMIT > DEC_DIGITS) ? WIDTH_LIMIT : DEC_DIGITS;
    localparam int CNT_W      = $clog2(MAX_CHARS + 1);
    localparam int ND_W       = $clog2(DEC_DIGITS + 1);
    localparam int DIG_IW     = $clog2(DEC_DIGITS);
    localparam int BIT_W      = $clog2(VALUE_BITS);
    localparam int BCD_W      = DEC_DIGITS * 4;

    // Configuration register port
    localparam int CFG_W  = 6;
    localparam int CMP_W  = (CNT_W > CFG_W) ? CNT_W : CFG_W;
    localparam int REG_IW = 3;
    localparam int ADDR_W = REG_IW + 2;
    localparam int DATA_W = 32;

    // Character codes
    localparam logic [7:0] CH_ZERO  = 8'h30;
    localparam logic [7:0] CH_SPACE = 8'h20;

    typedef enum logic [REG_IW-1:0] {
        REG_PRECISION   = 3'd0,
        REG_ZERO_FLAG   = 3'd1,
        REG_DOT_FLAG    = 3'd2,
        REG_ZERO_WIDTH  = 3'd3,
        REG_FIELD_WIDTH = 3'd4,
        REG_TRAIL_WIDTH = 3'd5
    } t_reg_idx;

    typedef struct packed {
        logic [CFG_W-1:0] precision_digits;
        logic             zero_flag;
        logic             dot_flag;
        logic [CFG_W-1:0] zero_width;
        logic [CFG_W-1:0] field_width;
        logic [CFG_W-1:0] trail_width;
    } t_cfg;

    // Controller to datapath commands
    typedef struct packed {
        logic load;
        logic shift;
        logic count;
        logic plan;
        logic emit;
    } t_dp_cmd;

    // Datapath to controller status
    typedef struct packed {
        logic empty;
        logic last;
        logic out_free;
    } t_dp_stat;

    // Saturate a register width at WIDTH_LIMIT
    function automatic logic [CNT_W-1:0] clamp_width(input logic [CFG_W-1:0] w);
        logic [CMP_W-1:0] wx;
        wx = CMP_W'(w);
        if (wx > CMP_W'(WIDTH_LIMIT)) begin
            return CNT_W'(WIDTH_LIMIT);
        end
        return CNT_W'(wx);
    endfunction

endpackage

### hw/rtl/udf_regs.sv
// Configuration register file of the decimal field formatter (APB-style).
// Depends on udf_pkg; drives the settings struct used by the datapath.
module udf_regs
    import udf_pkg::*;
(
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              psel,
    input  logic              penable,
    input  logic              pwrite,
    input  logic [ADDR_W-1:0] paddr,
    input  logic [DATA_W-1:0] pwdata,
    output logic [DATA_W-1:0] prdata,
    output logic              pready,
    output t_cfg              o_cfg
);

    t_cfg     r_cfg;
    t_reg_idx w_idx;
    logic     w_wr;

    assign w_idx  = t_reg_idx'(paddr[ADDR_W-1:2]);
    assign w_wr   = psel && penable && pwrite;
    assign pready = 1'b1;
    assign o_cfg  = r_cfg;

    // Write on the access phase; drop writes to unknown indexes
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg <= '0;
        end else if (w_wr) begin
            unique case (w_idx)
                REG_PRECISION:   r_cfg.precision_digits <= pwdata[CFG_W-1:0];
                REG_ZERO_FLAG:   r_cfg.zero_flag        <= pwdata[0];
                REG_DOT_FLAG:    r_cfg.dot_flag         <= pwdata[0];
                REG_ZERO_WIDTH:  r_cfg.zero_width       <= pwdata[CFG_W-1:0];
                REG_FIELD_WIDTH: r_cfg.field_width      <= pwdata[CFG_W-1:0];
                REG_TRAIL_WIDTH: r_cfg.trail_width      <= pwdata[CFG_W-1:0];
                default: begin
                end
            endcase
        end
    end

    // Read back the addressed register
    always_comb begin
        unique case (w_idx)
            REG_PRECISION:   prdata = DATA_W'(r_cfg.precision_digits);
            REG_ZERO_FLAG:   prdata = DATA_W'(r_cfg.zero_flag);
            REG_DOT_FLAG:    prdata = DATA_W'(r_cfg.dot_flag);
            REG_ZERO_WIDTH:  prdata = DATA_W'(r_cfg.zero_width);
            REG_FIELD_WIDTH: prdata = DATA_W'(r_cfg.field_width);
            REG_TRAIL_WIDTH: prdata = DATA_W'(r_cfg.trail_width);
            default:         prdata = '0;
        endcase
    end

endmodule

### hw/rtl/udf_ctrl.sv
// Sequencer of the decimal field formatter: accept, convert, size, emit.
// Depends on udf_pkg; issues commands to udf_dp and reads its status.
module udf_ctrl
    import udf_pkg::*;
(
    input  logic     i_clk,
    input  logic     i_rst_n,
    input  logic     i_valid,
    output logic     o_ready,
    input  t_dp_stat i_stat,
    output t_dp_cmd  o_cmd
);

    typedef enum logic [2:0] {
        S_IDLE,
        S_CONV,
        S_COUNT,
        S_PLAN,
        S_EMIT
    } t_state;

    t_state           r_state, n_state;
    logic [BIT_W-1:0] r_bit, n_bit;
    logic             r_in_ready;

    assign o_ready = r_in_ready;

    // Decode commands and the next state
    always_comb begin
        o_cmd   = '0;
        n_state = r_state;
        n_bit   = r_bit;
        unique case (r_state)
            S_IDLE: begin
                if (i_valid && r_in_ready) begin
                    o_cmd.load = 1'b1;
                    n_bit      = BIT_W'(VALUE_BITS - 1);
                    n_state    = S_CONV;
                end
            end
            S_CONV: begin
                o_cmd.shift = 1'b1;
                n_bit       = r_bit - 1'b1;
                if (r_bit == '0) begin
                    n_state = S_COUNT;
                end
            end
            S_COUNT: begin
                o_cmd.count = 1'b1;
                n_state     = S_PLAN;
            end
            S_PLAN: begin
                o_cmd.plan = 1'b1;
                n_state    = S_EMIT;
            end
            S_EMIT: begin
                if (i_stat.empty) begin
                    n_state = S_IDLE;
                end else if (i_stat.out_free) begin
                    o_cmd.emit = 1'b1;
                    if (i_stat.last) begin
                        n_state = S_IDLE;
                    end
                end
            end
            default: n_state = S_IDLE;
        endcase
    end

    // Hold state, bit counter and the registered input ready
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state    <= S_IDLE;
            r_bit      <= '0;
            r_in_ready <= 1'b1;
        end else begin
            r_state    <= n_state;
            r_bit      <= n_bit;
            r_in_ready <= (n_state == S_IDLE);
        end
    end

endmodule

### hw/rtl/udf_dp.sv
// Datapath of the decimal field formatter: shift-add-3 conversion, field
// layout and the character output register. Depends on udf_pkg.
module udf_dp
    import udf_pkg::*;
(
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  t_dp_cmd               i_cmd,
    input  t_cfg                  i_cfg,
    input  logic [VALUE_BITS-1:0] i_value,
    input  logic                  i_out_ready,
    output t_dp_stat              o_stat,
    output logic                  o_out_valid,
    output logic [7:0]            o_char_code,
    output logic                  o_last_char
);

    // Conversion state
    logic [VALUE_BITS-1:0] r_bin;
    logic [BCD_W-1:0]      r_bcd;
    logic [BCD_W-1:0]      n_bcd_adj;
    logic [ND_W-1:0]       r_ndig, n_ndig;

    // Field layout
    logic [CNT_W-1:0]  r_end_fill, r_end_zero, r_end_body, r_total;
    logic [CNT_W-1:0]  r_pos;
    logic [DIG_IW-1:0] r_didx;
    logic [7:0]        r_fill_ch;
    logic              r_blank;

    // Output register
    logic       r_out_valid;
    logic [7:0] r_char;
    logic       r_last;

    // Layout terms
    logic [CNT_W-1:0] w_prec, w_width0, w_width, w_trail, w_ndig, w_min_len;
    logic [CNT_W-1:0] w_nfill, w_nzero, w_nout, w_body;
    logic             w_blank, w_space_fill;

    // Character selection
    logic [3:0] w_digit;
    logic [7:0] w_char;
    logic       w_is_digit;

    // Add 3 to every digit at five or above before the shift
    always_comb begin
        for (int i = 0; i < DEC_DIGITS; i++) begin
            if (r_bcd[i*4 +: 4] >= 4'd5) begin
                n_bcd_adj[i*4 +: 4] = r_bcd[i*4 +: 4] + 4'd3;
            end else begin
                n_bcd_adj[i*4 +: 4] = r_bcd[i*4 +: 4];
            end
        end
    end

    // Find the count of significant digits, at least one
    always_comb begin
        n_ndig = ND_W'(1);
        for (int i = 1; i < DEC_DIGITS; i++) begin
            if (r_bcd[i*4 +: 4] != 4'd0) begin
                n_ndig = ND_W'(i + 1);
            end
        end
    end

    // Lay out fill, precision zeros, digits and trailing spaces
    always_comb begin
        w_prec     = clamp_width(i_cfg.precision_digits);
        w_trail    = clamp_width(i_cfg.trail_width);
        w_width0   = clamp_width(i_cfg.zero_flag ? i_cfg.zero_width : i_cfg.field_width);
        w_width    = (w_prec > w_width0) ? w_prec : w_width0;
        w_ndig     = CNT_W'(r_ndig);
        w_min_len  = (w_prec > w_ndig) ? w_prec : w_ndig;
        w_nfill    = (w_width > w_min_len) ? (w_width - w_min_len) : '0;
        w_nzero    = (w_prec > w_ndig) ? (w_prec - w_ndig) : '0;
        w_blank    = (r_ndig == ND_W'(1)) && (r_bcd[3:0] == 4'd0)
                     && i_cfg.dot_flag && (w_prec == '0);
        if (w_blank) begin
            w_nout = (w_width != '0) ? CNT_W'(1) : '0;
        end else begin
            w_nout = w_ndig;
        end
        w_body       = w_nfill + w_nzero + w_nout;
        w_space_fill = !i_cfg.zero_flag
                       || (i_cfg.dot_flag && (clamp_width(i_cfg.zero_width) > w_prec));
    end

    // Pick the character at the current position
    always_comb begin
        w_digit    = r_bcd[r_didx*4 +: 4];
        w_is_digit = 1'b0;
        if (r_pos < r_end_fill) begin
            w_char = r_fill_ch;
        end else if (r_pos < r_end_zero) begin
            w_char = CH_ZERO;
        end else if (r_pos < r_end_body) begin
            w_is_digit = !r_blank;
            w_char     = r_blank ? CH_SPACE : (CH_ZERO | {4'd0, w_digit});
        end else begin
            w_char = CH_SPACE;
        end
    end

    // Conversion registers
    always_ff @(posedge i_clk) begin
        if (i_cmd.load) begin
            r_bin <= i_value;
            r_bcd <= '0;
        end else if (i_cmd.shift) begin
            r_bin <= {r_bin[VALUE_BITS-2:0], 1'b0};
            r_bcd <= {n_bcd_adj[BCD_W-2:0], r_bin[VALUE_BITS-1]};
        end
        if (i_cmd.count) begin
            r_ndig <= n_ndig;
        end
    end

    // Layout registers and emit counters
    always_ff @(posedge i_clk) begin
        if (i_cmd.plan) begin
            r_end_fill <= w_nfill;
            r_end_zero <= w_nfill + w_nzero;
            r_end_body <= w_body;
            r_total    <= (w_trail > w_body) ? w_trail : w_body;
            r_fill_ch  <= w_space_fill ? CH_SPACE : CH_ZERO;
            r_blank    <= w_blank;
            r_pos      <= '0;
            r_didx     <= DIG_IW'(r_ndig - 1'b1);
        end else if (i_cmd.emit) begin
            r_pos <= r_pos + 1'b1;
            if (w_is_digit) begin
                r_didx <= r_didx - 1'b1;
            end
        end
    end

    // Output register: load on emit, drop on transfer
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (i_cmd.emit) begin
            r_out_valid <= 1'b1;
        end else if (i_out_ready) begin
            r_out_valid <= 1'b0;
        end
        if (i_cmd.emit) begin
            r_char <= w_char;
            r_last <= (r_pos == r_total - 1'b1);
        end
    end

    assign o_stat.empty    = (r_total == '0);
    assign o_stat.last     = (r_pos == r_total - 1'b1);
    assign o_stat.out_free = !r_out_valid || i_out_ready;
    assign o_out_valid     = r_out_valid;
    assign o_char_code     = r_char;
    assign o_last_char     = r_last;

endmodule

### hw/rtl/unsigned_decimal_field_formatter.sv
// Flow: an accepted value passes through the serial shift-add-3 converter, a digit count
// step and a layout step; then its characters (none, or 1..62) leave one per cycle while the
// output is not stalled. A new value is accepted only after the last character is emitted.
// Reset: synchronous, active low; clears settings to 0 and drops any value in flight.
module unsigned_decimal_field_formatter
    import udf_pkg::*;
(
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              psel,
    input  logic              penable,
    input  logic              pwrite,
    input  logic [ADDR_W-1:0] paddr,
    input  logic [DATA_W-1:0] pwdata,
    output logic [DATA_W-1:0] prdata,
    output logic              pready,
    input  logic              i_valid,
    output logic              o_ready,
    input  logic [63:0]       i_value,
    output logic              o_valid,
    input  logic              i_ready,
    output logic [7:0]        o_char_code,
    output logic              o_last_char
);

    t_cfg     w_cfg;
    t_dp_cmd  w_cmd;
    t_dp_stat w_stat;

    // Settings registers
    udf_regs u_regs (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .pready  (pready),
        .o_cfg   (w_cfg)
    );

    // Sequencer
    udf_ctrl u_ctrl (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_valid (i_valid),
        .o_ready (o_ready),
        .i_stat  (w_stat),
        .o_cmd   (w_cmd)
    );

    // Conversion and character datapath
    udf_dp u_dp (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cmd       (w_cmd),
        .i_cfg       (w_cfg),
        .i_value     (i_value[VALUE_BITS-1:0]),
        .i_out_ready (i_ready),
        .o_stat      (w_stat),
        .o_out_valid (o_valid),
        .o_char_code (o_char_code),
        .o_last_char (o_last_char)
    );

endmodule

### hw/rtl/udf_checker.sv
// Port-level checker for the decimal field formatter, bound to the top level.
// Depends on udf_pkg and unsigned_decimal_field_formatter_assert.svh.
`include "unsigned_decimal_field_formatter_assert.svh"

module udf_checker
    import udf_pkg::*;
(
    input logic       i_clk,
    input logic       i_rst_n,
    input logic       i_valid,
    input logic       o_ready,
    input logic       o_valid,
    input logic       i_ready,
    input logic [7:0] o_char_code,
    input logic       o_last_char
);

    // Reset empties the output register
    `UDF_ASSERT_ALWAYS(a_reset_clears_out, i_clk, !i_rst_n |=> !o_valid, "output valid after reset")

    // An accepted value blocks the input until its characters are out
    `UDF_ASSERT(a_busy_after_accept, i_clk, i_rst_n, (i_valid && o_ready) |=> !o_ready, "input ready right after a transfer")

    // Only digits and spaces leave the block
    `UDF_ASSERT(a_char_set, i_clk, i_rst_n, o_valid |-> ((o_char_code == CH_SPACE) || ((o_char_code >= CH_ZERO) && (o_char_code <= (CH_ZERO + 8'd9)))), "character is neither digit nor space")

    // A stalled character holds
    `UDF_ASSERT(a_out_hold, i_clk, i_rst_n, (o_valid && !i_ready) |=> (o_valid && $stable(o_char_code) && $stable(o_last_char)), "stalled character changed")

endmodule

bind unsigned_decimal_field_formatter udf_checker u_udf_checker (.*);
